### src/back_forward_history_stacks_defines.svh
// ----------------------------------------------------------------------------
// back/forward history stacks: assertion macros
// shared concurrent check forms, clocked on aclk and off during reset
// ----------------------------------------------------------------------------
`ifndef BACK_FORWARD_HISTORY_STACKS_DEFINES_SVH
`define BACK_FORWARD_HISTORY_STACKS_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define BFHS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BFHS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

### src/bfhs_pkg.sv
// ----------------------------------------------------------------------------
// bfhs_pkg
// types, constants and index helpers for the back/forward history stacks
// ----------------------------------------------------------------------------
package bfhs_pkg;

    localparam int HISTORY_DEPTH = 128;
    localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W = IDX_W + 1;
    localparam int ENTRY_W = 64;

    localparam logic [1:0] ACT_VISIT   = 2'd0;
    localparam logic [1:0] ACT_BACK    = 2'd1;
    localparam logic [1:0] ACT_FORWARD = 2'd2;
    localparam logic [1:0] ACT_CLEAR   = 2'd3;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_BACK_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FWD_EMPTY  = 2'd2;

    typedef struct packed {
        logic [31:0] visit_time;
        logic [31:0] page_id;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } stack_ctl_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] count_next;
        logic [IDX_W-1:0] top_idx;
        logic [IDX_W-1:0] below_idx;
        logic [IDX_W-1:0] push_idx;
    } stack_info_t;

    // fold a sum below twice the depth back into the ring
    function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] sum);
        logic [SUM_W-1:0] adj;
        adj = sum - SUM_W'(HISTORY_DEPTH);
        return (sum >= SUM_W'(HISTORY_DEPTH)) ? adj[IDX_W-1:0] : sum[IDX_W-1:0];
    endfunction

    // low eight bits of a count
    function automatic logic [7:0] depth_byte(input logic [CNT_W-1:0] c);
        logic [CNT_W+7:0] ext;
        ext = {8'd0, c};
        return ext[7:0];
    endfunction

endpackage

### src/bfhs_ram.sv
// ----------------------------------------------------------------------------
// bfhs_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bfhs_ram #(
    parameter int DEPTH  = 128,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

### src/bfhs_stack.sv
// ----------------------------------------------------------------------------
// bfhs_stack
// head and fill count of one ring stack, with the slot indexes it needs
// ----------------------------------------------------------------------------
module bfhs_stack (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bfhs_pkg::stack_ctl_t ctl,
    output bfhs_pkg::stack_info_t info
);

    logic [bfhs_pkg::IDX_W-1:0] head_reg;
    logic [bfhs_pkg::IDX_W-1:0] head_next;
    logic [bfhs_pkg::CNT_W-1:0] count_reg;
    logic [bfhs_pkg::CNT_W-1:0] count_next;
    logic [bfhs_pkg::SUM_W-1:0] head_ext;
    logic [bfhs_pkg::SUM_W-1:0] count_ext;
    logic                       full;

    assign head_ext  = bfhs_pkg::SUM_W'(head_reg);
    assign count_ext = bfhs_pkg::SUM_W'(count_reg);
    assign full      = (count_reg == bfhs_pkg::CNT_W'(bfhs_pkg::HISTORY_DEPTH));

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        if (ctl.clear) begin
            head_next  = '0;
            count_next = '0;
        end else if (ctl.push) begin
            // a full ring drops its oldest entry
            if (full) begin
                head_next = bfhs_pkg::wrap_idx(head_ext + bfhs_pkg::SUM_W'(1));
            end else begin
                count_next = count_reg + bfhs_pkg::CNT_W'(1);
            end
        end else if (ctl.pop) begin
            count_next = count_reg - bfhs_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_comb begin
        info.count      = count_reg;
        info.count_next = count_next;
        info.top_idx    = bfhs_pkg::wrap_idx(head_ext + count_ext - bfhs_pkg::SUM_W'(1));
        info.below_idx  = bfhs_pkg::wrap_idx(head_ext + count_ext - bfhs_pkg::SUM_W'(2));
        info.push_idx   = full ? head_reg : bfhs_pkg::wrap_idx(head_ext + count_ext);
    end

endmodule

### src/back_forward_history_stacks.sv
// ----------------------------------------------------------------------------
// back_forward_history_stacks
// page history with a back stack and a forward stack, each a bounded ring
// ----------------------------------------------------------------------------
// requests arrive on the s_ channel (s_action, s_page_id, s_visit_time) with
// valid/ready; one result per request leaves on the m_ channel with the
// status, the current page and both stack depths.
// each request is accepted in the idle state, then finished in ST_FIN: in the
// accept cycle the stack memories are read (the entry below the back top, the
// forward top); in ST_FIN the registered read data is used, the moved entry
// goes to the other stack (forward moves the read top, back the current page),
// the pointers are updated and the result register is loaded. the result is
// valid once ST_FIN ends; no request is taken before the last is through.
// the top of the back stack is kept in a register, so back needs no read of
// the entry it moves.
// reset empties both stacks at once; memory contents are not cleared.
// a result waits in the output register while the receiver stalls; no new
// request is taken until that register is free or being drained.
// ----------------------------------------------------------------------------
`include "back_forward_history_stacks_defines.svh"

module back_forward_history_stacks (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [31:0] s_page_id,
    input  logic [31:0] s_visit_time,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_current_valid,
    output logic [31:0] m_current_page,
    output logic [31:0] m_current_time,
    output logic [7:0]  m_back_depth,
    output logic [7:0]  m_forward_depth
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_FIN  = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [1:0]  act_reg;
    logic [31:0] page_reg;
    logic [31:0] time_reg;

    bfhs_pkg::entry_t cur_reg;
    bfhs_pkg::entry_t cur_next;
    bfhs_pkg::entry_t back_wdata;
    bfhs_pkg::entry_t back_rdata;
    bfhs_pkg::entry_t fwd_rdata;

    bfhs_pkg::stack_ctl_t  back_ctl;
    bfhs_pkg::stack_ctl_t  fwd_ctl;
    bfhs_pkg::stack_info_t back_info;
    bfhs_pkg::stack_info_t fwd_info;

    logic       back_we;
    logic       fwd_we;
    logic [1:0] status_next;
    logic       accept;
    logic       cur_valid;
    logic       counts_ok;
    logic       visit_fin;

    logic        m_valid_reg;
    logic [1:0]  m_status_reg;
    logic        m_current_valid_reg;
    logic [31:0] m_current_page_reg;
    logic [31:0] m_current_time_reg;
    logic [7:0]  m_back_depth_reg;
    logic [7:0]  m_forward_depth_reg;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    bfhs_stack u_back_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (back_ctl),
        .info    (back_info)
    );

    bfhs_stack u_fwd_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (fwd_ctl),
        .info    (fwd_info)
    );

    // back reads the entry below its top, which becomes the new current page
    bfhs_ram #(
        .DEPTH (bfhs_pkg::HISTORY_DEPTH),
        .WIDTH (bfhs_pkg::ENTRY_W)
    ) u_back_ram (
        .aclk  (aclk),
        .we    (back_we),
        .waddr (back_info.push_idx),
        .wdata (back_wdata),
        .raddr (back_info.below_idx),
        .rdata (back_rdata)
    );

    bfhs_ram #(
        .DEPTH (bfhs_pkg::HISTORY_DEPTH),
        .WIDTH (bfhs_pkg::ENTRY_W)
    ) u_fwd_ram (
        .aclk  (aclk),
        .we    (fwd_we),
        .waddr (fwd_info.push_idx),
        .wdata (cur_reg),
        .raddr (fwd_info.top_idx),
        .rdata (fwd_rdata)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        back_ctl    = '0;
        fwd_ctl     = '0;
        back_we     = 1'b0;
        fwd_we      = 1'b0;
        back_wdata  = '{visit_time: time_reg, page_id: page_reg};
        cur_next    = cur_reg;
        status_next = bfhs_pkg::STATUS_OK;
        if (state_reg == ST_FIN) begin
            case (act_reg)
                bfhs_pkg::ACT_VISIT: begin
                    back_ctl.push = 1'b1;
                    back_we       = 1'b1;
                    fwd_ctl.clear = 1'b1;
                    cur_next      = back_wdata;
                end
                bfhs_pkg::ACT_BACK: begin
                    if (back_info.count == '0) begin
                        status_next = bfhs_pkg::STATUS_BACK_EMPTY;
                    end else begin
                        back_ctl.pop = 1'b1;
                        fwd_ctl.push = 1'b1;
                        fwd_we       = 1'b1;
                        cur_next     = back_rdata;
                    end
                end
                bfhs_pkg::ACT_FORWARD: begin
                    if (fwd_info.count == '0) begin
                        status_next = bfhs_pkg::STATUS_FWD_EMPTY;
                    end else begin
                        fwd_ctl.pop   = 1'b1;
                        back_ctl.push = 1'b1;
                        back_we       = 1'b1;
                        back_wdata    = fwd_rdata;
                        cur_next      = fwd_rdata;
                    end
                end
                default: begin
                    back_ctl.clear = 1'b1;
                    fwd_ctl.clear  = 1'b1;
                end
            endcase
        end
    end

    assign cur_valid = (back_info.count_next != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_FIN) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg  <= s_action;
            page_reg <= s_page_id;
            time_reg <= s_visit_time;
        end
        cur_reg <= cur_next;
        if (state_reg == ST_FIN) begin
            m_status_reg        <= status_next;
            m_current_valid_reg <= cur_valid;
            m_current_page_reg  <= cur_valid ? cur_next.page_id : 32'd0;
            m_current_time_reg  <= cur_valid ? cur_next.visit_time : 32'd0;
            m_back_depth_reg    <= bfhs_pkg::depth_byte(back_info.count_next);
            m_forward_depth_reg <= bfhs_pkg::depth_byte(fwd_info.count_next);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_current_valid = m_current_valid_reg;
    assign m_current_page  = m_current_page_reg;
    assign m_current_time  = m_current_time_reg;
    assign m_back_depth    = m_back_depth_reg;
    assign m_forward_depth = m_forward_depth_reg;

    assign counts_ok = (back_info.count <= bfhs_pkg::CNT_W'(bfhs_pkg::HISTORY_DEPTH))
                    && (fwd_info.count <= bfhs_pkg::CNT_W'(bfhs_pkg::HISTORY_DEPTH));
    assign visit_fin = (state_reg == ST_FIN) && (act_reg == bfhs_pkg::ACT_VISIT);

    `BFHS_ASSERT_NEXT(a_accept_to_fin, accept, state_reg == ST_FIN, "request not in writeback")
    `BFHS_ASSERT_NEXT(a_fin_gives_result, state_reg == ST_FIN, m_valid, "writeback gave no result")
    `BFHS_ASSERT_SAME(a_depth_bound, 1'b1, counts_ok, "stack count beyond history depth")
    `BFHS_ASSERT_NEXT(a_visit_clears_fwd, visit_fin, fwd_info.count == '0, "visit left forward entries")

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// back/forward history stacks testbench
// drives visit, back, forward and clear requests with random gaps and output
// stalls, predicts every result from a local copy of both history rings and
// compares each returned result field by field in order of arrival
// ----------------------------------------------------------------------------
module testbench;

    localparam int BACK_RING = 0;
    localparam int FWD_RING  = 1;

    typedef struct {
        logic [1:0]  status;
        logic        cur_valid;
        logic [31:0] cur_page;
        logic [31:0] cur_time;
        logic [7:0]  back_depth;
        logic [7:0]  fwd_depth;
    } nav_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action = bfhs_pkg::ACT_VISIT;
    logic [31:0] s_page_id = '0;
    logic [31:0] s_visit_time = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic        m_current_valid;
    logic [31:0] m_current_page;
    logic [31:0] m_current_time;
    logic [7:0]  m_back_depth;
    logic [7:0]  m_forward_depth;

    // history rings as the block should hold them
    logic [63:0] ring_mem [2][bfhs_pkg::HISTORY_DEPTH];
    int unsigned ring_head [2];
    int unsigned ring_count [2];

    nav_result_t pending_results [$];
    int          error_count = 0;
    bit          src_idle_on = 1'b1;
    bit          sink_idle_on = 1'b1;
    int          sink_hold_cycles = 0;

    back_forward_history_stacks u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_page_id       (s_page_id),
        .s_visit_time    (s_visit_time),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_current_valid (m_current_valid),
        .m_current_page  (m_current_page),
        .m_current_time  (m_current_time),
        .m_back_depth    (m_back_depth),
        .m_forward_depth (m_forward_depth)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function void ring_push(input int r, input logic [63:0] entry);
        if (ring_count[r] < bfhs_pkg::HISTORY_DEPTH) begin
            ring_mem[r][(ring_head[r] + ring_count[r]) % bfhs_pkg::HISTORY_DEPTH] = entry;
            ring_count[r]++;
        end else begin
            // full ring drops its oldest entry
            ring_mem[r][ring_head[r]] = entry;
            ring_head[r] = (ring_head[r] + 1) % bfhs_pkg::HISTORY_DEPTH;
        end
    endfunction

    function logic [63:0] ring_top(input int r);
        if (ring_count[r] == 0) return '0;
        return ring_mem[r][(ring_head[r] + ring_count[r] - 1) % bfhs_pkg::HISTORY_DEPTH];
    endfunction

    function logic [63:0] ring_pop(input int r);
        logic [63:0] entry;
        entry = ring_top(r);
        if (ring_count[r] != 0) ring_count[r]--;
        return entry;
    endfunction

    function void ring_clear(input int r);
        ring_head[r] = 0;
        ring_count[r] = 0;
    endfunction

    function nav_result_t predict_navigation(input logic [1:0] act, input logic [31:0] page,
                                             input logic [31:0] vtime);
        nav_result_t res;
        logic [63:0] cur;
        res.status = bfhs_pkg::STATUS_OK;
        case (act)
            bfhs_pkg::ACT_VISIT: begin
                ring_clear(FWD_RING);
                ring_push(BACK_RING, {vtime, page});
            end
            bfhs_pkg::ACT_BACK: begin
                if (ring_count[BACK_RING] == 0) res.status = bfhs_pkg::STATUS_BACK_EMPTY;
                else ring_push(FWD_RING, ring_pop(BACK_RING));
            end
            bfhs_pkg::ACT_FORWARD: begin
                if (ring_count[FWD_RING] == 0) res.status = bfhs_pkg::STATUS_FWD_EMPTY;
                else ring_push(BACK_RING, ring_pop(FWD_RING));
            end
            default: begin
                ring_clear(BACK_RING);
                ring_clear(FWD_RING);
            end
        endcase
        cur = ring_top(BACK_RING);
        res.cur_valid  = (ring_count[BACK_RING] != 0);
        res.cur_page   = cur[31:0];
        res.cur_time   = cur[63:32];
        res.back_depth = 8'(ring_count[BACK_RING]);
        res.fwd_depth  = 8'(ring_count[FWD_RING]);
        return res;
    endfunction

    task report_error(input string msg);
        error_count++;
        $display("%0t ERROR %s", $time, msg);
    endtask

    task check_field(input string name, input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
            report_error($sformatf("%s got %h want %h", name, got, want));
    endtask

    // results are checked in order against the oldest outstanding request
    always @(posedge aclk) begin : check_results
        nav_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_error("result with no request outstanding");
            end else begin
                want = pending_results.pop_front();
                check_field("status", 32'(m_status), 32'(want.status));
                check_field("current_valid", 32'(m_current_valid), 32'(want.cur_valid));
                check_field("current_page", m_current_page, want.cur_page);
                check_field("current_time", m_current_time, want.cur_time);
                check_field("back_depth", 32'(m_back_depth), 32'(want.back_depth));
                check_field("forward_depth", 32'(m_forward_depth), 32'(want.fwd_depth));
            end
        end
    end

    // result receiver: random stalls, plus a long hold when asked
    initial begin : result_sink
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (sink_hold_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (sink_hold_cycles) @(posedge aclk);
                sink_hold_cycles = 0;
            end
            stall = sink_idle_on ? $urandom_range(0, 11) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    task automatic send_request(input logic [1:0] act, input logic [31:0] page,
                                input logic [31:0] vtime);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= act;
        s_page_id    <= page;
        s_visit_time <= vtime;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(predict_navigation(act, page, vtime));
    endtask

    task wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] random_word();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return 32'h0000_0000;
        if (r == 1) return 32'hffff_ffff;
        return $urandom;
    endfunction

    function automatic logic [1:0] pick_action(input bit shuttle);
        int r;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 149) == 0) return bfhs_pkg::ACT_CLEAR;
        if (shuttle)
            return (r < 10) ? bfhs_pkg::ACT_VISIT :
                   (r < 55) ? bfhs_pkg::ACT_BACK : bfhs_pkg::ACT_FORWARD;
        return (r < 55) ? bfhs_pkg::ACT_VISIT :
               (r < 80) ? bfhs_pkg::ACT_BACK : bfhs_pkg::ACT_FORWARD;
    endfunction

    // empty stacks, field extremes, every action and the error cases
    task test_empty_history();
        send_request(bfhs_pkg::ACT_BACK, 32'hdead_beef, 32'h1234_5678);
        send_request(bfhs_pkg::ACT_FORWARD, 32'hffff_ffff, 32'hffff_ffff);
        send_request(bfhs_pkg::ACT_CLEAR, 32'h0, 32'h0);
        send_request(bfhs_pkg::ACT_VISIT, 32'h0000_0000, 32'h0000_0000);
        send_request(bfhs_pkg::ACT_VISIT, 32'hffff_ffff, 32'hffff_ffff);
        send_request(bfhs_pkg::ACT_VISIT, 32'haaaa_aaaa, 32'h5555_5555);
        send_request(bfhs_pkg::ACT_BACK, 32'hffff_ffff, 32'h0);
        send_request(bfhs_pkg::ACT_BACK, 32'h0, 32'h0);
        send_request(bfhs_pkg::ACT_BACK, 32'h0, 32'h0);
        send_request(bfhs_pkg::ACT_BACK, 32'h0, 32'h0);
        send_request(bfhs_pkg::ACT_FORWARD, 32'h1111_1111, 32'h2222_2222);
        send_request(bfhs_pkg::ACT_FORWARD, 32'h0, 32'h0);
        send_request(bfhs_pkg::ACT_VISIT, 32'h5555_5555, 32'haaaa_aaaa);
        send_request(bfhs_pkg::ACT_FORWARD, 32'h0, 32'h0);
        send_request(bfhs_pkg::ACT_BACK, 32'h0, 32'h0);
        send_request(bfhs_pkg::ACT_FORWARD, 32'h0, 32'h0);
        send_request(bfhs_pkg::ACT_BACK, 32'h0, 32'h0);
        send_request(bfhs_pkg::ACT_CLEAR, 32'hffff_ffff, 32'hffff_ffff);
        send_request(bfhs_pkg::ACT_FORWARD, 32'h0, 32'h0);
        send_request(bfhs_pkg::ACT_BACK, 32'h0, 32'h0);
        send_request(bfhs_pkg::ACT_VISIT, 32'h1234_5678, 32'h9abc_def0);
        wait_drained();
    endtask

    // overfill the back ring so reads and moves run across the wrap
    task test_ring_wrap();
        repeat (bfhs_pkg::HISTORY_DEPTH + 12) begin
            send_request(bfhs_pkg::ACT_VISIT, random_word(), random_word());
        end
        repeat (bfhs_pkg::HISTORY_DEPTH + 2) begin
            send_request(bfhs_pkg::ACT_BACK, random_word(), random_word());
        end
        repeat (bfhs_pkg::HISTORY_DEPTH + 2) begin
            send_request(bfhs_pkg::ACT_FORWARD, random_word(), random_word());
        end
        repeat (20) send_request(bfhs_pkg::ACT_VISIT, random_word(), random_word());
        wait_drained();
    endtask

    // receiver holds off while requests keep coming, so the input backs up
    task test_output_stall();
        src_idle_on = 1'b0;
        sink_hold_cycles = 150;
        repeat (12) send_request(pick_action(1'b0), random_word(), random_word());
        wait_drained();
        src_idle_on = 1'b1;
    endtask

    task test_random_walk(input int n_items);
        int  sent;
        int  seg_len;
        int  sel;
        bit  shuttle;
        sent = 0;
        while (sent < n_items) begin
            seg_len = $urandom_range(30, 120);
            sel = $urandom_range(0, 5);
            src_idle_on  = (sel == 1 || sel >= 3);
            sink_idle_on = (sel >= 2);
            shuttle = ($urandom_range(0, 2) == 0);
            repeat (seg_len) begin
                send_request(pick_action(shuttle), random_word(), random_word());
                sent++;
            end
            if ($urandom_range(0, 3) == 0) wait_drained();
        end
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        wait_drained();
    endtask

    initial begin : run_tests
        for (int r = 0; r < 2; r++) begin
            ring_head[r]  = 0;
            ring_count[r] = 0;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_history();
        test_ring_wrap();
        test_output_stall();
        test_random_walk(1100);
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : run_limit
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
